[design/pt_pkg.sv]
`timescale 1ns / 1ps

package pt_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_COLOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_USE  = 2'd2;

    // Result kinds and spawn status codes.
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic ST_ACCEPTED = 1'b0;
    localparam logic ST_FULL     = 1'b1;

    // Operand selection for the shared multiplier.
    typedef enum logic [2:0] {
        MS_VX  = 3'd0,
        MS_VY  = 3'd1,
        MS_AX  = 3'd2,
        MS_AY  = 3'd3,
        MS_AX2 = 3'd4,
        MS_AY2 = 3'd5,
        MS_DT2 = 3'd6,
        MS_COL = 3'd7
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       in_take;
        logic       mem_rd;
        logic       mem_wr;
        logic       load;
        logic       mul_en;
        mul_sel_t   mul_sel;
        logic       upd;
        logic       div_init;
        logic       div_step;
        logic       col_fin;
        logic [1:0] comp;
        logic       pend_load;
        logic       out_pend;
        logic       out_last;
        logic       out_status;
        logic       status_val;
    } pt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dead;
        logic out_free;
        logic pend_valid;
    } pt_stat_t;

endpackage

[design/pt_ifs.sv]
`timescale 1ns / 1ps

// Input word channel.
interface pt_item_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic        [15:0] dt;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic        [31:0] lifetime;

    modport source(output valid, action, dt, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
                   lifetime, input ready);
    modport sink(input valid, action, dt, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
                 lifetime, output ready);
endinterface

// Result word channel.
interface pt_result_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic               status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_vx;
    logic signed [31:0] out_vy;
    logic         [7:0] red;
    logic         [7:0] green;
    logic         [7:0] blue;
    logic         [7:0] alpha;
    logic               last;

    modport source(output valid, kind, status, out_x, out_y, out_vx, out_vy, red, green,
                   blue, alpha, last, input ready);
    modport sink(input valid, kind, status, out_x, out_y, out_vx, out_vy, red, green,
                 blue, alpha, last, output ready);
endinterface

// Configuration write channel.
interface pt_cfg_if;
    logic        valid;
    logic        ready;
    logic  [1:0] index;
    logic [31:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[design/pt_dp.sv]
`timescale 1ns / 1ps

module pt_dp #(
    parameter int MAX_PARTICLES = 64,
    parameter int AW = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pt_pkg::pt_cmd_t    cmd,
    input  logic [AW-1:0]      addr,
    input  logic        [15:0] dt,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] acc_x,
    input  logic signed [31:0] acc_y,
    input  logic        [31:0] lifetime,
    input  logic        [31:0] start_color,
    input  logic        [31:0] end_color,
    output pt_pkg::pt_stat_t   stat,
    pt_result_if.source        results
);

    // Saturate a 35-bit signed sum to 32 bits.
    function automatic logic [31:0] sat35(input logic [34:0] v);
        logic [31:0] r;
        if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111))
            r = v[31:0];
        else if (v[34])
            r = 32'h8000_0000;
        else
            r = 32'h7FFF_FFFF;
        return r;
    endfunction

    // One colour byte, red first.
    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] c);
        logic [7:0] r;
        case (c)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    // Particle table, one 256-bit row per particle.
    logic [255:0] mem [MAX_PARTICLES];
    logic [255:0] rdata_reg;
    logic [255:0] row_w;

    // Working particle.
    logic [31:0] px_reg, py_reg, vx_reg, vy_reg, ax_reg, ay_reg, age_reg, life_reg;
    logic [15:0] dt_reg;
    logic [31:0] dt2_reg;

    // Motion terms.
    logic [32:0] tvx_reg, tvy_reg, tax_reg, tay_reg;
    logic [30:0] qax_reg, qay_reg;

    // Colour divider.
    logic [40:0] num_reg;
    logic        neg_reg;
    logic [39:0] rem_reg;
    logic [38:0] dvs_reg;
    logic  [7:0] q_reg;
    logic [31:0] col_reg;

    // Pending record and output register.
    logic        pend_valid_reg;
    logic [31:0] pend_x_reg, pend_y_reg, pend_vx_reg, pend_vy_reg, pend_col_reg;
    logic        out_valid_reg;
    logic        out_kind_reg, out_status_reg, out_last_reg;
    logic [31:0] out_x_reg, out_y_reg, out_vx_reg, out_vy_reg, out_col_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic        [32:0] age_sum;
    logic        [31:0] age_sat;
    logic         [8:0] diff;
    logic         [7:0] s_byte, adj, c_byte;
    logic        [39:0] dvs_ext;
    logic               ge;

    assign row_w = {px_reg, py_reg, vx_reg, vy_reg, ax_reg, ay_reg, age_reg, life_reg};

    // Table access: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[addr] <= row_w;
        if (cmd.mem_rd)
            rdata_reg <= mem[addr];
    end

    // Saturating age update of the row just read.
    assign age_sum = {1'b0, rdata_reg[63:32]} + {17'b0, dt_reg};
    assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];

    // Colour difference of the current component.
    assign s_byte = byte_of(start_color, cmd.comp);
    assign diff   = {1'b0, byte_of(end_color, cmd.comp)} - {1'b0, s_byte};

    // Shared multiplier operands.
    always_comb
    begin
        case (cmd.mul_sel)
            pt_pkg::MS_VX:  begin mul_a = {vx_reg[31], vx_reg}; mul_b = {17'b0, dt_reg}; end
            pt_pkg::MS_VY:  begin mul_a = {vy_reg[31], vy_reg}; mul_b = {17'b0, dt_reg}; end
            pt_pkg::MS_AX:  begin mul_a = {ax_reg[31], ax_reg}; mul_b = {17'b0, dt_reg}; end
            pt_pkg::MS_AY:  begin mul_a = {ay_reg[31], ay_reg}; mul_b = {17'b0, dt_reg}; end
            pt_pkg::MS_AX2: begin mul_a = {ax_reg[31], ax_reg}; mul_b = {1'b0, dt2_reg}; end
            pt_pkg::MS_AY2: begin mul_a = {ay_reg[31], ay_reg}; mul_b = {1'b0, dt2_reg}; end
            pt_pkg::MS_DT2: begin mul_a = {17'b0, dt_reg};      mul_b = {17'b0, dt_reg}; end
            default:        begin mul_a = {1'b0, age_reg};      mul_b = {{24{diff[8]}}, diff}; end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Working particle registers.
    always_ff @(posedge clk)
    begin
        if (cmd.in_take)
        begin
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            vx_reg   <= vel_x;
            vy_reg   <= vel_y;
            ax_reg   <= acc_x;
            ay_reg   <= acc_y;
            age_reg  <= 32'd0;
            life_reg <= lifetime;
            dt_reg   <= dt;
        end
        else if (cmd.load)
        begin
            px_reg   <= rdata_reg[255:224];
            py_reg   <= rdata_reg[223:192];
            vx_reg   <= rdata_reg[191:160];
            vy_reg   <= rdata_reg[159:128];
            ax_reg   <= rdata_reg[127:96];
            ay_reg   <= rdata_reg[95:64];
            age_reg  <= age_sat;
            life_reg <= rdata_reg[31:0];
        end
        else if (cmd.upd)
        begin
            // Position uses the velocity from before this tick.
            px_reg <= sat35({{3{px_reg[31]}}, px_reg} + {{2{tvx_reg[32]}}, tvx_reg}
                            + {{4{qax_reg[30]}}, qax_reg});
            py_reg <= sat35({{3{py_reg[31]}}, py_reg} + {{2{tvy_reg[32]}}, tvy_reg}
                            + {{4{qay_reg[30]}}, qay_reg});
            vx_reg <= sat35({{3{vx_reg[31]}}, vx_reg} + {{2{tax_reg[32]}}, tax_reg});
            vy_reg <= sat35({{3{vy_reg[31]}}, vy_reg} + {{2{tay_reg[32]}}, tay_reg});
        end
    end

    // Motion products floored via their upper bits; dt squared and colour kept whole.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                pt_pkg::MS_VX:  tvx_reg <= prod[48:16];
                pt_pkg::MS_VY:  tvy_reg <= prod[48:16];
                pt_pkg::MS_AX:  tax_reg <= prod[48:16];
                pt_pkg::MS_AY:  tay_reg <= prod[48:16];
                pt_pkg::MS_AX2: qax_reg <= prod[63:33];
                pt_pkg::MS_AY2: qay_reg <= prod[63:33];
                pt_pkg::MS_DT2: dt2_reg <= prod[31:0];
                default:        num_reg <= prod[40:0];
            endcase
        end
    end

    // Restoring divide of |age*(e-s)| by the lifetime, one quotient bit a cycle.
    assign dvs_ext = {1'b0, dvs_reg};
    assign ge      = (rem_reg >= dvs_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            neg_reg <= num_reg[40];
            rem_reg <= num_reg[40] ? (~num_reg[39:0] + 40'd1) : num_reg[39:0];
            dvs_reg <= {life_reg, 7'b0};
            q_reg   <= 8'd0;
        end
        else if (cmd.div_step)
        begin
            if (ge)
                rem_reg <= rem_reg - dvs_ext;
            q_reg   <= {q_reg[6:0], ge};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    // Floor correction for negative ratios; a zero lifetime keeps the start byte.
    always_comb
    begin
        if (life_reg == 32'd0)
            adj = 8'd0;
        else if (!neg_reg)
            adj = q_reg;
        else if (rem_reg != 40'd0)
            adj = ~q_reg;
        else
            adj = ~q_reg + 8'd1;
        c_byte = s_byte + adj;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.col_fin)
        begin
            case (cmd.comp)
                2'd0:    col_reg[31:24] <= c_byte;
                2'd1:    col_reg[23:16] <= c_byte;
                2'd2:    col_reg[15:8]  <= c_byte;
                default: col_reg[7:0]   <= c_byte;
            endcase
        end
    end

    // Pending record: held until the next survivor or the end of the pass shows its last flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (cmd.pend_load)
            pend_valid_reg <= 1'b1;
        else if (cmd.out_pend)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pend_load)
        begin
            pend_x_reg   <= px_reg;
            pend_y_reg   <= py_reg;
            pend_vx_reg  <= vx_reg;
            pend_vy_reg  <= vy_reg;
            pend_col_reg <= col_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_pend || cmd.out_status)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_pend)
        begin
            out_kind_reg   <= pt_pkg::KIND_RECORD;
            out_status_reg <= pt_pkg::ST_ACCEPTED;
            out_x_reg      <= pend_x_reg;
            out_y_reg      <= pend_y_reg;
            out_vx_reg     <= pend_vx_reg;
            out_vy_reg     <= pend_vy_reg;
            out_col_reg    <= pend_col_reg;
            out_last_reg   <= cmd.out_last;
        end
        else if (cmd.out_status)
        begin
            out_kind_reg   <= pt_pkg::KIND_STATUS;
            out_status_reg <= cmd.status_val;
            out_x_reg      <= 32'd0;
            out_y_reg      <= 32'd0;
            out_vx_reg     <= 32'd0;
            out_vy_reg     <= 32'd0;
            out_col_reg    <= 32'd0;
            out_last_reg   <= 1'b1;
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.kind   = out_kind_reg;
    assign results.status = out_status_reg;
    assign results.out_x  = out_x_reg;
    assign results.out_y  = out_y_reg;
    assign results.out_vx = out_vx_reg;
    assign results.out_vy = out_vy_reg;
    assign results.red    = out_col_reg[31:24];
    assign results.green  = out_col_reg[23:16];
    assign results.blue   = out_col_reg[15:8];
    assign results.alpha  = out_col_reg[7:0];
    assign results.last   = out_last_reg;

    // Status back to the controller.
    assign stat.dead       = (age_reg > life_reg);
    assign stat.out_free   = !out_valid_reg;
    assign stat.pend_valid = pend_valid_reg;

endmodule

[design/pt_ctrl.sv]
`timescale 1ns / 1ps

module pt_ctrl #(
    parameter int MAX_PARTICLES = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_action,
    output logic             in_ready,
    input  logic [6:0]       max_in_use,
    input  pt_pkg::pt_stat_t stat,
    output pt_pkg::pt_cmd_t  cmd,
    output logic [AW-1:0]    addr
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_SPAWN = 15'b000000000000010,
        S_DT2   = 15'b000000000000100,
        S_RD    = 15'b000000000001000,
        S_LOAD  = 15'b000000000010000,
        S_CHECK = 15'b000000000100000,
        S_MUL   = 15'b000000001000000,
        S_UPD   = 15'b000000010000000,
        S_COLM  = 15'b000000100000000,
        S_COLA  = 15'b000001000000000,
        S_DIV   = 15'b000010000000000,
        S_COLF  = 15'b000100000000000,
        S_WR    = 15'b001000000000000,
        S_EMIT  = 15'b010000000000000,
        S_FLUSH = 15'b100000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   rd_addr_reg, rd_addr_next;
    logic [2:0]      step_reg, step_next;
    logic [1:0]      comp_reg, comp_next;
    logic            spawn_ok;
    logic [CW-1:0]   idx_inc;

    assign spawn_ok = (7'(count_reg) < max_in_use) && (32'(count_reg) < MAX_PARTICLES);
    assign idx_inc  = CW'(idx_reg) + CW'(1);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_addr_reg <= '0;
            step_reg    <= '0;
            comp_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_addr_reg <= rd_addr_next;
            step_reg    <= step_next;
            comp_reg    <= comp_next;
        end
    end

    // Sequencer: stores spawns and walks the table one particle at a time on a tick.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rd_addr_next = rd_addr_reg;
        step_next    = step_reg;
        comp_next    = comp_reg;
        cmd          = '0;
        cmd.comp     = comp_reg;
        addr         = idx_reg;
        in_ready     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_take = 1'b1;
                    state_next  = in_action ? S_SPAWN : S_DT2;
                end
            end
            S_SPAWN:
            begin
                addr = AW'(count_reg);
                if (stat.out_free)
                begin
                    cmd.out_status = 1'b1;
                    if (spawn_ok)
                    begin
                        cmd.mem_wr     = 1'b1;
                        cmd.status_val = pt_pkg::ST_ACCEPTED;
                        count_next     = count_reg + CW'(1);
                    end
                    else
                    begin
                        cmd.status_val = pt_pkg::ST_FULL;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DT2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = pt_pkg::MS_DT2;
                idx_next     = '0;
                rd_addr_next = '0;
                state_next   = (count_reg == '0) ? S_FLUSH : S_RD;
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                addr       = rd_addr_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.dead)
                begin
                    // The last entry takes this place and is checked in turn.
                    count_next = count_reg - CW'(1);
                    if (idx_inc == count_reg)
                        state_next = S_FLUSH;
                    else
                    begin
                        rd_addr_next = AW'(count_reg - CW'(1));
                        state_next   = S_RD;
                    end
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pt_pkg::mul_sel_t'(step_reg);
                if (step_reg == 3'd5)
                begin
                    step_next  = '0;
                    state_next = S_UPD;
                end
                else
                    step_next = step_reg + 3'd1;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                comp_next  = '0;
                state_next = S_COLM;
            end
            S_COLM:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pt_pkg::MS_COL;
                state_next  = S_COLA;
            end
            S_COLA:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == 3'd7)
                    state_next = S_COLF;
            end
            S_COLF:
            begin
                cmd.col_fin = 1'b1;
                if (comp_reg == 2'd3)
                    state_next = S_WR;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_COLM;
                end
            end
            S_WR:
            begin
                cmd.mem_wr = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.out_pend  = stat.pend_valid;
                    cmd.pend_load = 1'b1;
                    if (idx_inc < count_reg)
                    begin
                        idx_next     = AW'(idx_inc);
                        rd_addr_next = AW'(idx_inc);
                        state_next   = S_RD;
                    end
                    else
                        state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend_valid)
                    state_next = S_IDLE;
                else if (stat.out_free)
                begin
                    cmd.out_pend = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The table never holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_PARTICLES)
        else $error("live count above table depth");

    // The count moves only on a spawn or a death.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SPAWN && state_reg != S_CHECK) |=> $stable(count_reg))
        else $error("live count changed outside spawn or death");

    // A word is loaded into the output register only when it is empty.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_pend || cmd.out_status) |-> stat.out_free)
        else $error("output register overwritten");

endmodule

[design/particle_table_update.sv]
`timescale 1ns / 1ps

// Particle table: up to MAX_PARTICLES particles held in one on-chip table, one row each.
// A spawn word stores a particle if there is room and answers with one status word.
// A tick word walks the table one particle at a time through a single shared 33x33
// multiplier and a one-bit-per-cycle colour divider. Each survivor leaves as one
// record word; the last record of a tick is flagged and sent only once the pass is
// over. A new input word is taken when the previous one has finished; the output
// register lets the next word enter while the final result still waits.
// Configuration should be written only while the block is idle; the block itself
// does not enforce this.
module particle_table_update #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    pt_item_if.sink      items,
    pt_result_if.source  results,
    pt_cfg_if.sink       cfg
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    logic [31:0]      start_color_reg;
    logic [31:0]      end_color_reg;
    logic  [6:0]      max_in_use_reg;
    pt_pkg::pt_cmd_t  cmd;
    pt_pkg::pt_stat_t stat;
    logic [AW-1:0]    addr;
    logic             in_ready;

    // Configuration registers; unused indexes are ignored.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg <= 32'hFFFF_FFFF;
            end_color_reg   <= 32'hFFFF_FFFF;
            max_in_use_reg  <= 7'd64;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pt_pkg::CFG_START_COLOR: start_color_reg <= cfg.data;
                pt_pkg::CFG_END_COLOR:   end_color_reg   <= cfg.data;
                pt_pkg::CFG_MAX_IN_USE:  max_in_use_reg  <= cfg.data[6:0];
                default:                 ;
            endcase
        end
    end

    assign items.ready = in_ready;

    pt_ctrl #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .AW(AW),
        .CW(CW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(items.valid),
        .in_action(items.action),
        .in_ready(in_ready),
        .max_in_use(max_in_use_reg),
        .stat(stat),
        .cmd(cmd),
        .addr(addr)
    );

    pt_dp #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .AW(AW)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .addr(addr),
        .dt(items.dt),
        .pos_x(items.pos_x),
        .pos_y(items.pos_y),
        .vel_x(items.vel_x),
        .vel_y(items.vel_y),
        .acc_x(items.acc_x),
        .acc_y(items.acc_y),
        .lifetime(items.lifetime),
        .start_color(start_color_reg),
        .end_color(end_color_reg),
        .stat(stat),
        .results(results)
    );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_SIZE = 64;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4000;
    localparam logic [1:0] CFG_NONE = 2'd3;

    // One input word and one result word as the predictor sees them.
    typedef struct {
        logic        action;
        logic [15:0] dt;
        logic [31:0] px, py, vx, vy, ax, ay, life;
    } item_t;

    typedef struct {
        logic        kind;
        logic        status;
        logic [31:0] x, y, vx, vy;
        logic [7:0]  r, g, b, a;
        logic        last;
    } rec_t;

    // A directed row: the item plus an optional typed-in status.
    typedef struct {
        item_t it;
        bit    has_status;
        logic  status;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pt_item_if   items_ch();
    pt_result_if results_ch();
    pt_cfg_if    cfg_ch();

    particle_table_update dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items_ch.sink),
        .results(results_ch.source),
        .cfg    (cfg_ch.sink)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow of the particle table and registers.
    logic [31:0] sh_start, sh_end;
    logic [6:0]  sh_limit;
    int          sh_count;
    logic [31:0] t_px[TABLE_SIZE], t_py[TABLE_SIZE], t_vx[TABLE_SIZE], t_vy[TABLE_SIZE];
    logic [31:0] t_ax[TABLE_SIZE], t_ay[TABLE_SIZE], t_age[TABLE_SIZE], t_life[TABLE_SIZE];

    rec_t expected_words[$];
    int   error_count = 0;
    int   idle_pct = 33;
    int   stall_cycles = 0;
    bit   done_feed = 1'b0;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -128'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [7:0] blend(input int sh, input logic [31:0] age,
                                         input logic [31:0] life);
        longint s, e, num, q;
        s = (sh_start >> sh) & 8'hFF;
        e = (sh_end >> sh) & 8'hFF;
        if (life == 0)
            return s[7:0];
        num = longint'({32'd0, age}) * (e - s);
        q = num / longint'({32'd0, life});
        if (num % longint'({32'd0, life}) != 0 && num < 0)
            q = q - 1;
        return 8'(s + q);
    endfunction

    // Apply one accepted item to the shadow table and queue its results.
    task automatic predict_update(input item_t it);
        rec_t r;
        int i, n;
        logic signed [127:0] dt, vx, vy, ax, ay, nx, ny;
        logic [32:0] a;
        int lim;
        lim = (sh_limit > TABLE_SIZE) ? TABLE_SIZE : sh_limit;
        r = '{default: '0};
        if (it.action == 1'b1)
        begin
            r.kind = pt_pkg::KIND_STATUS;
            r.last = 1'b1;
            if (sh_count < lim)
            begin
                t_px[sh_count] = it.px; t_py[sh_count] = it.py;
                t_vx[sh_count] = it.vx; t_vy[sh_count] = it.vy;
                t_ax[sh_count] = it.ax; t_ay[sh_count] = it.ay;
                t_age[sh_count] = 0; t_life[sh_count] = it.life;
                sh_count++;
                r.status = pt_pkg::ST_ACCEPTED;
            end
            else
                r.status = pt_pkg::ST_FULL;
            expected_words.push_back(r);
            return;
        end
        dt = it.dt;
        i = 0;
        n = 0;
        while (i < sh_count)
        begin
            a = {1'b0, t_age[i]} + it.dt;
            t_age[i] = a[32] ? 32'hFFFF_FFFF : a[31:0];
            if (t_age[i] > t_life[i])
            begin
                sh_count--;
                t_px[i] = t_px[sh_count]; t_py[i] = t_py[sh_count];
                t_vx[i] = t_vx[sh_count]; t_vy[i] = t_vy[sh_count];
                t_ax[i] = t_ax[sh_count]; t_ay[i] = t_ay[sh_count];
                t_age[i] = t_age[sh_count]; t_life[i] = t_life[sh_count];
                continue;
            end
            vx = $signed(t_vx[i]); vy = $signed(t_vy[i]);
            ax = $signed(t_ax[i]); ay = $signed(t_ay[i]);
            nx = $signed(t_px[i]) + ((vx * dt) >>> 16) + ((ax * dt * dt) >>> 33);
            ny = $signed(t_py[i]) + ((vy * dt) >>> 16) + ((ay * dt * dt) >>> 33);
            t_px[i] = clamp32(nx);
            t_py[i] = clamp32(ny);
            t_vx[i] = clamp32(vx + ((ax * dt) >>> 16));
            t_vy[i] = clamp32(vy + ((ay * dt) >>> 16));
            r = '{default: '0};
            r.kind = pt_pkg::KIND_RECORD;
            r.x = t_px[i]; r.y = t_py[i]; r.vx = t_vx[i]; r.vy = t_vy[i];
            r.r = blend(24, t_age[i], t_life[i]);
            r.g = blend(16, t_age[i], t_life[i]);
            r.b = blend(8, t_age[i], t_life[i]);
            r.a = blend(0, t_age[i], t_life[i]);
            expected_words.push_back(r);
            n++;
            i++;
        end
        if (n > 0)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endtask

    // Result side: random back-pressure and field-by-field compare.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_ch.ready <= 1'b0;
        else
            results_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        rec_t e;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (expected_words.size() == 0)
                report("result word with nothing expected");
            else
            begin
                e = expected_words.pop_front();
                if (results_ch.kind !== e.kind)
                    report($sformatf("kind %0d exp %0d", results_ch.kind, e.kind));
                if (results_ch.status !== e.status)
                    report($sformatf("status %0d exp %0d", results_ch.status, e.status));
                if (results_ch.out_x !== e.x)
                    report($sformatf("out_x %h exp %h", results_ch.out_x, e.x));
                if (results_ch.out_y !== e.y)
                    report($sformatf("out_y %h exp %h", results_ch.out_y, e.y));
                if (results_ch.out_vx !== e.vx)
                    report($sformatf("out_vx %h exp %h", results_ch.out_vx, e.vx));
                if (results_ch.out_vy !== e.vy)
                    report($sformatf("out_vy %h exp %h", results_ch.out_vy, e.vy));
                if (results_ch.red !== e.r)
                    report($sformatf("red %h exp %h", results_ch.red, e.r));
                if (results_ch.green !== e.g)
                    report($sformatf("green %h exp %h", results_ch.green, e.g));
                if (results_ch.blue !== e.b)
                    report($sformatf("blue %h exp %h", results_ch.blue, e.b));
                if (results_ch.alpha !== e.a)
                    report($sformatf("alpha %h exp %h", results_ch.alpha, e.a));
                if (results_ch.last !== e.last)
                    report($sformatf("last %0d exp %0d", results_ch.last, e.last));
            end
        end
    end

    // Watchdog: cycles with no word accepted anywhere.
    always @(posedge clk)
    begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Write one register and drop valid again before the next write.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == pt_pkg::CFG_START_COLOR)
            sh_start = val;
        else if (idx == pt_pkg::CFG_END_COLOR)
            sh_end = val;
        else if (idx == pt_pkg::CFG_MAX_IN_USE)
            sh_limit = val[6:0];
        @(posedge clk);
    endtask

    // Send one word, idling first at random; the block is busy the cycle after.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        items_ch.action   <= it.action;
        items_ch.dt       <= it.dt;
        items_ch.pos_x    <= it.px;
        items_ch.pos_y    <= it.py;
        items_ch.vel_x    <= it.vx;
        items_ch.vel_y    <= it.vy;
        items_ch.acc_x    <= it.ax;
        items_ch.acc_y    <= it.ay;
        items_ch.lifetime <= it.life;
        items_ch.valid    <= 1'b1;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        items_ch.valid <= 1'b0;
        predict_update(it);
        @(posedge clk);
    endtask

    // Wait until every expected word is back and the block has settled.
    task automatic drain();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic item_t spawn_of(input logic [31:0] p, input logic [31:0] v,
                                       input logic [31:0] a, input logic [31:0] life);
        item_t it;
        it = '{action: 1'b1, dt: 16'($urandom), px: p, py: ~p, vx: v, vy: ~v,
               ax: a, ay: ~a, life: life};
        return it;
    endfunction

    function automatic item_t tick_of(input logic [15:0] dt);
        item_t it;
        it = '{action: 1'b0, dt: dt, px: $urandom, py: $urandom, vx: $urandom,
               vy: $urandom, ax: $urandom, ay: $urandom, life: $urandom};
        return it;
    endfunction

    function automatic item_t random_spawn();
        logic [31:0] life;
        case ($urandom_range(3))
            0: life = $urandom_range(65535);
            1: life = $urandom_range(1 << 20);
            2: life = $urandom;
            default: life = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        endcase
        return spawn_of($urandom, $urandom, $urandom, life);
    endfunction

    // Directed rows: extremes, both actions, zero lifetime, saturation.
    row_t rows[$];

    initial
    begin
        item_t it;
        int k;
        items_ch.valid = 1'b0; items_ch.action = 1'b0; items_ch.dt = '0;
        items_ch.pos_x = '0; items_ch.pos_y = '0; items_ch.vel_x = '0;
        items_ch.vel_y = '0; items_ch.acc_x = '0; items_ch.acc_y = '0;
        items_ch.lifetime = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        sh_start = 32'hFFFF_FFFF; sh_end = 32'hFFFF_FFFF; sh_limit = 7'd64; sh_count = 0;

        rows.push_back('{tick_of(16'hFFFF), 1'b0, 1'b0});
        rows.push_back('{spawn_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'hFFFF_FFFF), 1'b1, pt_pkg::ST_ACCEPTED});
        rows.push_back('{spawn_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'hFFFF_FFFF), 1'b1, pt_pkg::ST_ACCEPTED});
        rows.push_back('{spawn_of(32'd0, 32'd0, 32'd0, 32'd0), 1'b1, pt_pkg::ST_ACCEPTED});
        rows.push_back('{spawn_of(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                                  32'h0002_0000), 1'b1, pt_pkg::ST_ACCEPTED});
        rows.push_back('{tick_of(16'd0), 1'b0, 1'b0});
        rows.push_back('{tick_of(16'h8000), 1'b0, 1'b0});
        rows.push_back('{tick_of(16'hFFFF), 1'b0, 1'b0});
        rows.push_back('{tick_of(16'hFFFF), 1'b0, 1'b0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: default colors, directed rows.
        foreach (rows[j])
        begin
            send_item(rows[j].it);
            if (rows[j].has_status
                && expected_words[expected_words.size() - 1].status !== rows[j].status)
                report("directed row status disagrees with predictor");
        end
        drain();

        // Phase 2: extreme colors, a small limit, fill past it.
        write_reg(pt_pkg::CFG_START_COLOR, 32'h00FF_00FF);
        write_reg(pt_pkg::CFG_END_COLOR, 32'hFF00_FF00);
        write_reg(pt_pkg::CFG_MAX_IN_USE, 32'd4);
        for (k = 0; k < 6; k++)
            send_item(spawn_of($urandom, $urandom, $urandom, 32'h0004_0000));
        send_item(tick_of(16'h4000));
        drain();

        // Limit below the count, zero limit, unused index write.
        write_reg(pt_pkg::CFG_MAX_IN_USE, 32'd1);
        send_item(random_spawn());
        drain();
        write_reg(CFG_NONE, 32'hFFFF_FFFF);
        write_reg(pt_pkg::CFG_MAX_IN_USE, 32'd0);
        send_item(random_spawn());
        send_item(tick_of(16'h1000));
        drain();
        write_reg(pt_pkg::CFG_MAX_IN_USE, 32'd127);

        // Random phases: mostly spawns so the table fills, with changing colors.
        for (k = 0; k < 230; k++)
        begin
            idle_pct = (k >= 80 && k < 120) ? 0 : 33;
            if (k % 60 == 59)
            begin
                drain();
                write_reg(pt_pkg::CFG_START_COLOR, $urandom);
                write_reg(pt_pkg::CFG_END_COLOR, $urandom);
                write_reg(pt_pkg::CFG_MAX_IN_USE, $urandom_range(127));
            end
            if ($urandom_range(99) < 65)
                send_item(random_spawn());
            else if ($urandom_range(3) == 0)
                send_item(tick_of(16'($urandom)));
            else
                send_item(tick_of(16'($urandom_range(2048))));
        end
        idle_pct = 33;
        drain();

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

[sim.f]
design/pt_pkg.sv
design/pt_ifs.sv
design/pt_dp.sv
design/pt_ctrl.sv
design/particle_table_update.sv
dv/testbench.sv
